FILE: rtl/plid_pkg.sv
// plid_pkg: shared types and codes for the positional list core.
// Holds the request/response structs, operation and status codes.
// No dependencies.
package plid_pkg;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam int unsigned POS_W  = 7;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned LEN_W  = 7;

    typedef struct packed {
        logic [1:0]              operation;
        logic [POS_W-1:0]        position;
        logic signed [WORD_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] word_out;
        logic [LEN_W-1:0]        length_now;
        logic [1:0]              status;
    } t_rsp;

    // shift command broadcast along the row of cells
    typedef struct packed {
        logic ins;   // open a gap at the position, later entries move up
        logic del;   // close the gap at the position, later entries move down
    } t_shift;

endpackage

FILE: rtl/plid_cell.sv
// plid_cell: one list slot of the shift chain.
// Holds one word and takes its neighbour's word on a shift.
// Depends on plid_pkg.
module plid_cell #(
    parameter int unsigned IDX_W = 7,
    parameter int unsigned IDX   = 0
) (
    input  logic                                i_clk,
    input  plid_pkg::t_shift                    i_cmd,
    input  logic [IDX_W-1:0]                    i_pos,
    input  logic signed [plid_pkg::WORD_W-1:0]  i_value,
    input  logic signed [plid_pkg::WORD_W-1:0]  i_left,
    input  logic signed [plid_pkg::WORD_W-1:0]  i_right,
    output logic signed [plid_pkg::WORD_W-1:0]  o_entry,
    output logic signed [plid_pkg::WORD_W-1:0]  o_sel_word
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic signed [plid_pkg::WORD_W-1:0] r_entry;
    logic signed [plid_pkg::WORD_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins && (MY_IDX > i_pos)) begin
            n_entry = i_left;
        end else if (i_cmd.ins && (MY_IDX == i_pos)) begin
            n_entry = i_value;
        end else if (i_cmd.del && (MY_IDX >= i_pos)) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry    = r_entry;
    assign o_sel_word = (MY_IDX == i_pos) ? r_entry : '0;

endmodule

FILE: rtl/positional_list_insert_delete_core.sv
// positional_list_insert_delete_core: fixed-capacity ordered list of words.
// Top level: request decode, count, row of plid_cell slots, read fold.
// Depends on plid_pkg and plid_cell.
//
//  channel   | ports            | handshake
//  ----------+------------------+------------------------------------------
//  request   | start, i_req     | transfer when start high and busy low
//  response  | o_done, o_rsp    | one-cycle strobe, no back-pressure
//
// One request per cycle; its response strobe is registered in r_s1_valid,
// then o_done. The shift of the whole row happens at the transfer edge,
// so a following request sees the updated list straight away. The read
// path is split: slot words are folded into groups of eight and registered,
// then the groups are folded into the response register.
// busy is high only while reset is held. Reset clears the count and the
// response valid flags; the slot words and response data are left as is.
module positional_list_insert_delete_core #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  plid_pkg::t_req   i_req,
    output logic             o_done,
    output plid_pkg::t_rsp   o_rsp
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    // compare width: wide enough for the position field and the count
    localparam int unsigned CW    = (CNT_W > plid_pkg::POS_W) ? CNT_W : plid_pkg::POS_W;
    localparam int unsigned GRP   = 8;
    localparam int unsigned NG    = (CAPACITY + GRP - 1) / GRP;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic                 accept;
    logic [CW-1:0]        pos_ext;
    logic [CW-1:0]        cnt_ext;
    logic                 ins_ok;
    logic                 del_ok;
    logic                 rd_ok;
    logic [1:0]           stat;
    plid_pkg::t_shift     shift;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    logic signed [plid_pkg::WORD_W-1:0] w_entry [CAPACITY];
    logic signed [plid_pkg::WORD_W-1:0] w_sel   [CAPACITY];
    logic signed [plid_pkg::WORD_W-1:0] n_grp   [NG];

    // stage 1: decoded result and group folds
    logic signed [plid_pkg::WORD_W-1:0] r_grp [NG];
    logic                 r_s1_valid;
    logic                 r_s1_hit;
    logic [1:0]           r_s1_stat;
    logic [plid_pkg::LEN_W-1:0] r_s1_len;

    logic signed [plid_pkg::WORD_W-1:0] word_fold;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    assign pos_ext = CW'(i_req.position);
    assign cnt_ext = CW'(r_count);

    // Request decode. Insert range check precedes the full check; an empty
    // list wins over range on delete and read; unused opcode reports range.
    always_comb begin
        ins_ok = 1'b0;
        del_ok = 1'b0;
        rd_ok  = 1'b0;
        stat   = plid_pkg::ST_OK;
        case (i_req.operation)
            plid_pkg::OP_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    stat = plid_pkg::ST_RANGE;
                end else if (cnt_ext == CAP_C) begin
                    stat = plid_pkg::ST_FULL;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            plid_pkg::OP_DELETE, plid_pkg::OP_READ: begin
                if (cnt_ext == '0) begin
                    stat = plid_pkg::ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    stat = plid_pkg::ST_RANGE;
                end else begin
                    rd_ok  = 1'b1;
                    del_ok = (i_req.operation == plid_pkg::OP_DELETE);
                end
            end
            default: begin
                stat = plid_pkg::ST_RANGE;
            end
        endcase
    end

    assign shift.ins = accept & ins_ok;
    assign shift.del = accept & del_ok;

    always_comb begin
        n_count = r_count;
        if (shift.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (shift.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Row of slots: each takes its left neighbour on insert, its right neighbour
    // on delete. Slot 0's left tie-off is unused; the last slot keeps its word.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [plid_pkg::WORD_W-1:0] left_w;
        logic signed [plid_pkg::WORD_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = i_req.value;
        end else begin : g_mid_l
            assign left_w = w_entry[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_w = w_entry[i];
        end else begin : g_mid_r
            assign right_w = w_entry[i+1];
        end

        plid_cell #(
            .IDX_W (CW),
            .IDX   (i)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (shift),
            .i_pos      (pos_ext),
            .i_value    (i_req.value),
            .i_left     (left_w),
            .i_right    (right_w),
            .o_entry    (w_entry[i]),
            .o_sel_word (w_sel[i])
        );
    end

    // group folds of the selected slot word; at most one slot is selected
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < CAPACITY) begin
                    n_grp[g] = n_grp[g] | w_sel[g * GRP + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NG; g++) begin
            r_grp[g] <= n_grp[g];
        end
        r_s1_hit  <= rd_ok;
        r_s1_stat <= stat;
        r_s1_len  <= plid_pkg::LEN_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            o_done     <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            o_done     <= r_s1_valid;
        end
    end

    always_comb begin
        word_fold = '0;
        for (int g = 0; g < NG; g++) begin
            word_fold = word_fold | r_grp[g];
        end
    end

    // stage 2: response register
    always_ff @(posedge i_clk) begin
        o_rsp.word_out   <= r_s1_hit ? word_fold : '0;
        o_rsp.length_now <= r_s1_len;
        o_rsp.status     <= r_s1_stat;
    end

endmodule

FILE: rtl/plid_chk.sv
// plid_chk: port-level checks on the positional list core.
// Bound to positional_list_insert_delete_core; depends on plid_pkg.
module plid_chk #(
    parameter int unsigned CAPACITY = 64
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input logic            o_done,
    input plid_pkg::t_rsp  o_rsp
);

    localparam logic [plid_pkg::LEN_W-1:0] CAP_L = plid_pkg::LEN_W'(CAPACITY);

    a_resp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("transfer without response two cycles later");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##2 !o_done)
        else $error("response without a transfer");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.length_now <= CAP_L))
        else $error("length beyond capacity");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status != plid_pkg::ST_OK)) |-> (o_rsp.word_out == '0))
        else $error("failed request returned a word");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == plid_pkg::ST_EMPTY)) |-> (o_rsp.length_now == '0))
        else $error("empty status with non-zero length");

endmodule

bind positional_list_insert_delete_core plid_chk #(
    .CAPACITY (CAPACITY)
) u_plid_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
